FILE: sv/pes_pkg.sv
// pes_pkg: types and constants for the pointer extrapolate / smooth unit.
// Used by the channel interfaces, pes_lane and the top level.
package pes_pkg;

  localparam int POS_W   = 16;
  localparam int STAMP_W = 48;
  localparam int AVG_W   = 32;
  localparam int COEF_W  = 16;
  localparam int REQ_W   = 2;

  // Serial multiplier takes one multiplier bit per step, divider one quotient bit.
  localparam int MUL_STEPS = COEF_W;
  localparam int ACC_W     = 64;
  localparam int DIV_STEPS = ACC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  // Operand widths inside a lane.
  localparam int MCAND_W = STAMP_W + 1;   // signed, holds |dt| or avg delta
  localparam int QUO_W   = POS_W + 2;     // enough for the quotient clamp
  localparam logic [QUO_W-1:0] QUO_CLAMP = QUO_W'(18'h20000);

  localparam logic [COEF_W-1:0] SMOOTH_RESET = COEF_W'(52429);

  localparam logic [REQ_W-1:0] REQ_RECORD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PREDICT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SMOOTH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FOLD,
    ST_FIN
  } pes_state_e;

  // Where the result of a transaction comes from.
  typedef enum logic [1:0] {
    RK_ZERO,
    RK_NEWEST,
    RK_RAW,
    RK_LANE
  } pes_kind_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic fold;
  } pes_lane_cmd_t;

endpackage

FILE: sv/pes_req_if.sv
// pes_req_if: request channel of the pointer unit (valid/ready plus payload).
// Depends on pes_pkg for field widths.
interface pes_req_if;
  import pes_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [REQ_W-1:0]   req_type;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic        [STAMP_W-1:0] stamp;

  modport source (output valid, req_type, pos_x, pos_y, stamp, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, stamp, output ready);
endinterface

FILE: sv/pes_rsp_if.sv
// pes_rsp_if: result channel of the pointer unit (valid/ready plus payload).
// Depends on pes_pkg for field widths.
interface pes_rsp_if;
  import pes_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   out_x;
  logic signed [POS_W-1:0]   out_y;
  logic        [STAMP_W-1:0] out_stamp;

  modport source (output valid, out_x, out_y, out_stamp, input ready);
  modport sink   (input valid, out_x, out_y, out_stamp, output ready);
endinterface

FILE: sv/pes_lane.sv
// pes_lane: one axis of arithmetic; bit-serial shift-add multiplier followed by
// a restoring divider, plus the final clamp / blend fold. Depends on pes_pkg.
module pes_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pes_pkg::pes_lane_cmd_t        cmd_i,
  input  logic [pes_pkg::COEF_W-1:0]    ld_mplier_i,
  input  logic signed [pes_pkg::MCAND_W-1:0] ld_mcand_i,
  input  logic [pes_pkg::STAMP_W-1:0]   ld_divisor_i,
  input  logic signed [pes_pkg::POS_W-1:0] ld_base_i,
  input  logic                          ld_neg_i,
  input  logic                          ld_smooth_i,
  output logic signed [pes_pkg::POS_W-1:0] res_o,
  output logic [pes_pkg::AVG_W-1:0]     avg_o
);
  import pes_pkg::*;

  logic [COEF_W-1:0]        mplier_q, mplier_d;
  logic signed [MCAND_W-1:0] mcand_q;
  logic [STAMP_W-1:0]       divisor_q;
  logic signed [POS_W-1:0]  base_q;
  logic                     neg_q, smooth_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [STAMP_W:0]         rem_q, rem_d;
  logic [QUO_W-1:0]         quo_q, quo_d;
  logic                     big_q, big_d;
  logic signed [POS_W-1:0]  pred_q, pred_d;
  logic [AVG_W-1:0]         avg_q, avg_d;

  logic [STAMP_W:0]         rem_sh;
  logic                     rem_ge;
  logic [QUO_W-1:0]         quo_clamped;
  logic signed [QUO_W:0]    quo_signed;
  logic signed [QUO_W:0]    pred_sum;
  logic [AVG_W-1:0]         avg_round;

  // Multiply / divide step
  always_comb begin
    rem_sh   = {rem_q[STAMP_W-1:0], acc_q[ACC_W-1]};
    rem_ge   = (rem_sh >= {1'b0, divisor_q});
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    big_d    = big_q;
    if (cmd_i.load) begin
      mplier_d = ld_mplier_i;
      acc_d    = '0;
      rem_d    = '0;
      quo_d    = '0;
      big_d    = 1'b0;
    end else if (cmd_i.mul_step) begin
      mplier_d = {mplier_q[COEF_W-2:0], 1'b0};
      acc_d    = {acc_q[ACC_W-2:0], 1'b0} +
                 (mplier_q[COEF_W-1] ? ACC_W'(mcand_q) : ACC_W'(0));
    end else if (cmd_i.div_step) begin
      acc_d = {acc_q[ACC_W-2:0], 1'b0};
      rem_d = rem_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
      quo_d = {quo_q[QUO_W-2:0], rem_ge};
      big_d = big_q | quo_q[QUO_W-1];
    end
  end

  // Fold: clamp, sign and saturate for predict; blend for smooth
  always_comb begin
    quo_clamped = (big_q || (quo_q > QUO_CLAMP)) ? QUO_CLAMP : quo_q;
    quo_signed  = neg_q ? -$signed({1'b0, quo_clamped}) : $signed({1'b0, quo_clamped});
    pred_sum    = (QUO_W+1)'(base_q) + quo_signed;
    if (pred_sum > (QUO_W+1)'(32767)) begin
      pred_d = 16'sh7fff;
    end else if (pred_sum < -(QUO_W+1)'(32768)) begin
      pred_d = -16'sh8000;
    end else begin
      pred_d = pred_sum[POS_W-1:0];
    end
    // floor((raw*2^32 + D*f) / 2^16) = raw*2^16 + (D*f >>> 16)
    avg_d = {base_q, {(AVG_W-POS_W){1'b0}}} + acc_q[AVG_W+POS_W-1:POS_W];
  end

  always_ff @(posedge clk_i) begin
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    big_q    <= big_d;
    if (cmd_i.load) begin
      mcand_q   <= ld_mcand_i;
      divisor_q <= ld_divisor_i;
      base_q    <= ld_base_i;
      neg_q     <= ld_neg_i;
      smooth_q  <= ld_smooth_i;
    end
    if (cmd_i.fold) begin
      pred_q <= pred_d;
      avg_q  <= avg_d;
    end
  end

  // Truncate the Q16.16 average toward zero
  assign avg_round = avg_q + (avg_q[AVG_W-1] ? AVG_W'(16'hffff) : AVG_W'(0));
  assign res_o     = smooth_q ? avg_round[AVG_W-1:AVG_W-POS_W] : pred_q;
  assign avg_o     = avg_q;

  // reset is only used by the assertions below
`ifndef SYNTHESIS
  a_div_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !cmd_i.mul_step && !cmd_i.load)
    else $error("lane: divide step overlaps load or multiply");
  a_quo_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> quo_q == '0 && !big_q && rem_q == '0)
    else $error("lane: divider state not cleared on load");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.fold) && !smooth_q |-> quo_clamped <= QUO_CLAMP)
    else $error("lane: quotient above clamp");
`endif
endmodule

FILE: sv/pointer_extrapolate_smooth_unit.sv
// pointer_extrapolate_smooth_unit: pointer predictor and smoother, top level.
// Depends on pes_pkg, pes_req_if, pes_rsp_if and pes_lane.
//
// Keeps the two most recent recorded pointer samples and a Q16.16 moving
// average. A record transaction stores the sample on acceptance and gives no
// result. A predict transaction with two distinct-time samples extrapolates
// both axes in parallel lanes: a 16-step bit-serial multiply of |delta| by |dt|
// followed by a 64-step restoring divide by |vdt|, one quotient bit a cycle.
// A blending smooth transaction runs only the 16-step multiply. Predict without
// usable history and smooth with a zero average go straight to the finish
// state; request type 3 is accepted and gives no result. One transaction is in
// flight at a time; the result sits in an output register, so the next request
// is taken while the previous result waits for the sink. The blend weight is an
// unsigned Q0.16 weight of the old average, written via blend_wt_we_i; the user
// must write it only while the unit is idle, which the block does not enforce.
// It resets to 52429 (about 0.8).
module pointer_extrapolate_smooth_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        blend_wt_we_i,
  input  logic [pes_pkg::COEF_W-1:0]  blend_wt_i,
  pes_req_if.sink                     req_chan,
  pes_rsp_if.source                   rsp_chan
);
  import pes_pkg::*;

  // Configuration
  logic [COEF_W-1:0] smooth_f_q;

  // Tracked pointer history and average
  logic signed [POS_W-1:0] older_x_q, older_y_q, newest_x_q, newest_y_q;
  logic [STAMP_W-1:0]      older_time_q, newest_time_q;
  logic [1:0]              sample_cnt_q;
  logic [AVG_W-1:0]        avg_x_q, avg_y_q;

  // Transaction in flight
  pes_state_e              state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [REQ_W-1:0]        req_q;
  pes_kind_e               kind_q, kind_d;
  logic signed [POS_W-1:0] px_q, py_q;
  logic [STAMP_W-1:0]      stamp_q;
  logic signed [STAMP_W:0] dt_q, vdt_q;

  // Output register
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic [STAMP_W-1:0]      out_stamp_q;

  logic                    req_fire, slot_free, fin_fire, avg_zero, hist_ok;
  pes_lane_cmd_t           lane_cmd;

  // Lane operands
  logic signed [POS_W:0]     dx, dy;
  logic [STAMP_W-1:0]        dt_abs, vdt_abs;
  logic signed [AVG_W:0]     sdx, sdy;
  logic [COEF_W-1:0]         mpl_x, mpl_y;
  logic signed [MCAND_W-1:0] mc_x, mc_y;
  logic signed [POS_W-1:0]   base_x, base_y;
  logic                      neg_x, neg_y, is_smooth;
  logic signed [POS_W-1:0]   lane_res_x, lane_res_y;
  logic [AVG_W-1:0]          lane_avg_x, lane_avg_y;

  assign req_fire  = req_chan.valid && req_chan.ready;
  assign slot_free = !out_valid_q || rsp_chan.ready;
  assign avg_zero  = (avg_x_q == '0) && (avg_y_q == '0);
  assign hist_ok   = (sample_cnt_q == 2'd2) && (older_time_q != newest_time_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_chan.req_type == REQ_PREDICT) begin
            state_d = hist_ok ? ST_PREP : ST_FIN;
          end else if (req_chan.req_type == REQ_SMOOTH) begin
            state_d = avg_zero ? ST_FIN : ST_PREP;
          end
        end
      end
      ST_PREP: state_d = ST_MUL;
      ST_MUL: begin
        if (step_q == MUL_LAST) begin
          state_d = (req_q == REQ_SMOOTH) ? ST_FOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: state_d = ST_FIN;
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    req_chan.ready    = 1'b0;
    lane_cmd          = '0;
    fin_fire          = 1'b0;
    step_d            = '0;
    unique case (state_q)
      ST_IDLE: req_chan.ready = 1'b1;
      ST_PREP: lane_cmd.load = 1'b1;
      ST_MUL: begin
        lane_cmd.mul_step = 1'b1;
        step_d            = (step_q == MUL_LAST) ? '0 : step_q + 1'b1;
      end
      ST_DIV: begin
        lane_cmd.div_step = 1'b1;
        step_d            = step_q + 1'b1;
      end
      ST_FOLD: lane_cmd.fold = 1'b1;
      ST_FIN:  fin_fire = slot_free;
      default: ;
    endcase
  end

  // Result source, decided from the history at acceptance
  always_comb begin
    kind_d = RK_LANE;
    if (req_chan.req_type == REQ_PREDICT) begin
      if (sample_cnt_q == 2'd0) begin
        kind_d = RK_ZERO;
      end else if (!hist_ok) begin
        kind_d = RK_NEWEST;
      end
    end else if (avg_zero) begin
      kind_d = RK_RAW;
    end
  end

  // Operand prep: magnitudes and signs for predict, avg - raw for smooth
  always_comb begin
    is_smooth = (req_q == REQ_SMOOTH);
    dx        = (POS_W+1)'(newest_x_q) - (POS_W+1)'(older_x_q);
    dy        = (POS_W+1)'(newest_y_q) - (POS_W+1)'(older_y_q);
    dt_abs    = dt_q[STAMP_W]  ? STAMP_W'(-dt_q)  : dt_q[STAMP_W-1:0];
    vdt_abs   = vdt_q[STAMP_W] ? STAMP_W'(-vdt_q) : vdt_q[STAMP_W-1:0];
    sdx       = $signed({avg_x_q[AVG_W-1], avg_x_q}) -
                $signed({px_q[POS_W-1], px_q, {(AVG_W-POS_W){1'b0}}});
    sdy       = $signed({avg_y_q[AVG_W-1], avg_y_q}) -
                $signed({py_q[POS_W-1], py_q, {(AVG_W-POS_W){1'b0}}});
    if (is_smooth) begin
      mpl_x  = smooth_f_q;
      mpl_y  = smooth_f_q;
      mc_x   = MCAND_W'(sdx);
      mc_y   = MCAND_W'(sdy);
      base_x = px_q;
      base_y = py_q;
      neg_x  = 1'b0;
      neg_y  = 1'b0;
    end else begin
      mpl_x  = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
      mpl_y  = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
      mc_x   = $signed({1'b0, dt_abs});
      mc_y   = $signed({1'b0, dt_abs});
      base_x = newest_x_q;
      base_y = newest_y_q;
      neg_x  = dx[POS_W] ^ dt_q[STAMP_W] ^ vdt_q[STAMP_W];
      neg_y  = dy[POS_W] ^ dt_q[STAMP_W] ^ vdt_q[STAMP_W];
    end
  end

  pes_lane u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (lane_cmd),
    .ld_mplier_i  (mpl_x),
    .ld_mcand_i   (mc_x),
    .ld_divisor_i (vdt_abs),
    .ld_base_i    (base_x),
    .ld_neg_i     (neg_x),
    .ld_smooth_i  (is_smooth),
    .res_o        (lane_res_x),
    .avg_o        (lane_avg_x)
  );

  pes_lane u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (lane_cmd),
    .ld_mplier_i  (mpl_y),
    .ld_mcand_i   (mc_y),
    .ld_divisor_i (vdt_abs),
    .ld_base_i    (base_y),
    .ld_neg_i     (neg_y),
    .ld_smooth_i  (is_smooth),
    .res_o        (lane_res_y),
    .avg_o        (lane_avg_y)
  );

  // Control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      smooth_f_q    <= SMOOTH_RESET;
      older_x_q     <= '0;
      older_y_q     <= '0;
      newest_x_q    <= '0;
      newest_y_q    <= '0;
      older_time_q  <= '0;
      newest_time_q <= '0;
      sample_cnt_q  <= '0;
      avg_x_q       <= '0;
      avg_y_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (blend_wt_we_i) begin
        smooth_f_q <= blend_wt_i;
      end
      // Record: shift history, seed a zero average
      if (req_fire && req_chan.req_type == REQ_RECORD) begin
        older_x_q     <= newest_x_q;
        older_y_q     <= newest_y_q;
        older_time_q  <= newest_time_q;
        newest_x_q    <= req_chan.pos_x;
        newest_y_q    <= req_chan.pos_y;
        newest_time_q <= req_chan.stamp;
        if (sample_cnt_q != 2'd2) begin
          sample_cnt_q <= sample_cnt_q + 2'd1;
        end
        if (avg_zero) begin
          avg_x_q <= {req_chan.pos_x, {(AVG_W-POS_W){1'b0}}};
          avg_y_q <= {req_chan.pos_y, {(AVG_W-POS_W){1'b0}}};
        end
      end
      // Smooth commits its average when the result is handed over
      if (fin_fire && req_q == REQ_SMOOTH) begin
        if (kind_q == RK_RAW) begin
          avg_x_q <= {px_q, {(AVG_W-POS_W){1'b0}}};
          avg_y_q <= {py_q, {(AVG_W-POS_W){1'b0}}};
        end else begin
          avg_x_q <= lane_avg_x;
          avg_y_q <= lane_avg_y;
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction payload capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q   <= req_chan.req_type;
      kind_q  <= kind_d;
      px_q    <= req_chan.pos_x;
      py_q    <= req_chan.pos_y;
      stamp_q <= req_chan.stamp;
      dt_q    <= $signed({1'b0, req_chan.stamp}) - $signed({1'b0, newest_time_q});
      vdt_q   <= $signed({1'b0, newest_time_q}) - $signed({1'b0, older_time_q});
    end
    if (fin_fire) begin
      out_stamp_q <= stamp_q;
      case (kind_q)
        RK_ZERO: begin
          out_x_q <= '0;
          out_y_q <= '0;
        end
        RK_NEWEST: begin
          out_x_q <= newest_x_q;
          out_y_q <= newest_y_q;
        end
        RK_RAW: begin
          out_x_q <= px_q;
          out_y_q <= py_q;
        end
        default: begin
          out_x_q <= lane_res_x;
          out_y_q <= lane_res_y;
        end
      endcase
    end
  end

  assign rsp_chan.valid     = out_valid_q;
  assign rsp_chan.out_x     = out_x_q;
  assign rsp_chan.out_y     = out_y_q;
  assign rsp_chan.out_stamp = out_stamp_q;

`ifndef SYNTHESIS
  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && slot_free) |=> rsp_chan.valid && state_q == ST_IDLE)
    else $error("finished transaction not placed in output register");
  a_sample_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_cnt_q != 2'd3)
    else $error("sample count past two");
  a_record_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_chan.req_type == REQ_RECORD) |=> state_q == ST_IDLE)
    else $error("record transaction started a computation");
  a_predict_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_chan.req_type == REQ_PREDICT && hist_ok) |=> state_q == ST_PREP)
    else $error("predict with history skipped the lanes");
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && step_q != MUL_LAST) |=> state_q == ST_MUL)
    else $error("multiply left early");
`endif
endmodule
